[hdl/hec_pkg.sv]
// ----------------------------------------------------------------------------
// Hermite expansion coefficient - shared package
// Word types, configuration bundle and Q16.47 constants.
// ----------------------------------------------------------------------------
package hec_pkg;

	localparam int FRAC_BITS = 47;
	localparam int MAX_POWER = 4;
	localparam int ROW_LEN   = 2 * MAX_POWER + 1;
	localparam int EXP_TERMS = 16;

	localparam logic [63:0] ONE_Q  = 64'h0000_8000_0000_0000;
	localparam logic [63:0] HALF_Q = 64'h0000_4000_0000_0000;
	localparam logic [63:0] LN2_Q  = 64'h0000_58B9_0BFB_E8E8;
	localparam logic [63:0] Q_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] Q_MIN  = 64'h8000_0000_0000_0000;

	localparam logic [1:0] REG_LEFT_CENTER    = 2'd0;
	localparam logic [1:0] REG_LEFT_EXPONENT  = 2'd1;
	localparam logic [1:0] REG_RIGHT_CENTER   = 2'd2;
	localparam logic [1:0] REG_RIGHT_EXPONENT = 2'd3;

	typedef struct packed {
		logic [2:0] left_power;
		logic [2:0] right_power;
		logic [3:0] hermite_degree;
	} hec_in_t;

	typedef struct packed {
		logic signed [63:0] coefficient;
		logic               overflow;
	} hec_out_t;

	typedef struct packed {
		logic signed [63:0] left_center;
		logic [62:0]        left_exponent;
		logic signed [63:0] right_center;
		logic [62:0]        right_exponent;
	} hec_cfg_t;

endpackage

[hdl/hec_qmul.sv]
// ----------------------------------------------------------------------------
// Hermite expansion coefficient - Q16.47 multiplier
// Four 32x32 partial products accumulated in turn, then round and saturate.
// ----------------------------------------------------------------------------
module hec_qmul (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [63:0] a,
	input  logic signed [63:0] b,
	output logic               done,
	output logic signed [63:0] prod,
	output logic               sat
);
	import hec_pkg::*;

	logic         busy_q, fin_q, done_q, neg_q, sat_q;
	logic [1:0]   cnt_q;
	logic [63:0]  ma_q, mb_q, prod_q;
	logic [127:0] acc_q;
	logic [31:0]  pa, pb;
	logic [63:0]  pp, mag;
	logic [127:0] sh, rnd;
	logic [63:0]  res;
	logic         res_sat;

	always_comb begin
		pa = cnt_q[0] ? ma_q[63:32] : ma_q[31:0];
		pb = cnt_q[1] ? mb_q[63:32] : mb_q[31:0];
		pp = pa * pb;
		case (cnt_q)
			2'd0: sh = {64'd0, pp};
			2'd3: sh = {pp, 64'd0};
			default: sh = {32'd0, pp, 32'd0};
		endcase
		rnd = acc_q + {64'd0, HALF_Q};
		mag = rnd[110:47];
		res_sat = 1'b0;
		if (|rnd[127:111]) begin
			res_sat = 1'b1;
			res = neg_q ? Q_MIN : Q_MAX;
		end else if (neg_q) begin
			if (mag > Q_MIN) begin
				res_sat = 1'b1;
				res = Q_MIN;
			end else begin
				res = ~mag + 64'd1;
			end
		end else if (mag[63]) begin
			res_sat = 1'b1;
			res = Q_MAX;
		end else begin
			res = mag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 2'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd3) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end else if (fin_q) begin
				fin_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ma_q  <= a[63] ? (~a + 64'd1) : a;
			mb_q  <= b[63] ? (~b + 64'd1) : b;
			neg_q <= a[63] ^ b[63];
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_q + sh;
		end else if (fin_q) begin
			prod_q <= res;
			sat_q  <= res_sat;
		end
	end

	assign done = done_q;
	assign prod = prod_q;
	assign sat  = sat_q;

endmodule

[hdl/hec_qdiv.sv]
// ----------------------------------------------------------------------------
// Hermite expansion coefficient - restoring divider
// One quotient bit a cycle over a top-aligned dividend; saturates at max.
// ----------------------------------------------------------------------------
module hec_qdiv (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [110:0]  dvd,
	input  logic [63:0]   den,
	input  logic [6:0]    iters,
	output logic          done,
	output logic [63:0]   quo,
	output logic [63:0]   rem,
	output logic          sat
);
	import hec_pkg::*;

	logic         busy_q, done_q, ovf_q;
	logic [6:0]   cnt_q;
	logic [110:0] dvd_q;
	logic [63:0]  den_q, rem_q, q_q;
	logic [64:0]  trial, diff;
	logic         ge;

	always_comb begin
		trial = {rem_q, dvd_q[110]};
		diff  = trial - {1'b0, den_q};
		ge    = trial >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= iters;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dvd;
			den_q <= den;
			rem_q <= '0;
			q_q   <= '0;
			ovf_q <= 1'b0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[109:0], 1'b0};
			rem_q <= ge ? diff[63:0] : trial[63:0];
			q_q   <= {q_q[62:0], ge};
			ovf_q <= ovf_q | q_q[63];
		end
	end

	assign sat  = ovf_q | q_q[63] | (den_q == 64'd0);
	assign quo  = sat ? Q_MAX : q_q;
	assign rem  = rem_q;
	assign done = done_q;

endmodule

[hdl/hec_seq.sv]
// ----------------------------------------------------------------------------
// Hermite expansion coefficient - sequencer
// Set-up, exponential seed and level-by-level fill on the shared units.
// ----------------------------------------------------------------------------
module hec_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  hec_pkg::hec_in_t  in_word,
	input  hec_pkg::hec_cfg_t cfg,
	input  logic              out_free,
	output logic              busy,
	output logic              done,
	output hec_pkg::hec_out_t result
);
	import hec_pkg::*;

	typedef enum logic [18:0] {
		S_IDLE   = 19'h00001,
		S_SETUP  = 19'h00002,
		S_DGO    = 19'h00004,
		S_DWAIT  = 19'h00008,
		S_MGO    = 19'h00010,
		S_MWAIT  = 19'h00020,
		S_XMGO   = 19'h00040,
		S_XMWAIT = 19'h00080,
		S_XDGO   = 19'h00100,
		S_XDWAIT = 19'h00200,
		S_SCALE  = 19'h00400,
		S_CLEAR  = 19'h00800,
		S_FRD    = 19'h01000,
		S_FGO    = 19'h02000,
		S_FWAIT  = 19'h04000,
		S_FWR    = 19'h08000,
		S_ORD    = 19'h10000,
		S_OLAT   = 19'h20000,
		S_DONE   = 19'h40000
	} state_t;

	localparam logic [3:0] ST_HALF = 4'd0;
	localparam logic [3:0] ST_BP   = 4'd1;
	localparam logic [3:0] ST_AP   = 4'd2;
	localparam logic [3:0] ST_XPA  = 4'd3;
	localparam logic [3:0] ST_XPB  = 4'd4;
	localparam logic [3:0] ST_MU   = 4'd5;
	localparam logic [3:0] ST_XX   = 4'd6;
	localparam logic [3:0] ST_ARG  = 4'd7;
	localparam logic [3:0] ST_LN2  = 4'd8;

	localparam logic [2:0] PMAX      = 3'(MAX_POWER);
	localparam logic [3:0] LAST_CELL = 4'(ROW_LEN - 1);
	localparam logic [6:0] IT_Q      = 7'(64 + FRAC_BITS);
	localparam logic [6:0] IT_INT    = 7'd64;
	localparam logic [6:0] IT_K      = 7'(FRAC_BITS + 1);

	state_t state_q;
	logic [3:0]  step_q, cell_q, tdeg_q;
	logic [1:0]  term_q;
	logic [2:0]  i_q, j_q, lvl_q;
	logic [4:0]  k_q;
	logic        cur_q, ovf_q;
	logic signed [63:0] x_q, d0_q, bp_q, ap_q, xpa_q, xpb_q, mu_q, xx_q, arg_q;
	logic [63:0] n_q, r_q, acc_q, tmp_q, e00_q, s_q, coef_q;
	logic [63:0] mem [2][ROW_LEN];
	logic [63:0] rd_data_q;

	logic [2:0]  ic, jc;
	logic        clamp;
	logic [3:0]  total, tot_q;
	logic [64:0] xdiff, ssum;
	logic [63:0] xsat, ssat, scaled, p;
	logic        xs, ss;
	logic        rd_row;
	logic [3:0]  rd_cell;

	logic              mul_start, mul_done, mul_sat;
	logic signed [63:0] mul_a, mul_b, mul_p;
	logic              div_start, div_done, div_sat;
	logic [110:0]      div_dvd;
	logic [63:0]       div_den, div_quo, div_rem;
	logic [6:0]        div_it;

	always_comb begin
		ic    = (in_word.left_power > PMAX) ? PMAX : in_word.left_power;
		jc    = (in_word.right_power > PMAX) ? PMAX : in_word.right_power;
		clamp = (in_word.left_power > PMAX) | (in_word.right_power > PMAX);
		total = {1'b0, ic} + {1'b0, jc};
		p     = {1'b0, cfg.left_exponent} + {1'b0, cfg.right_exponent};

		xdiff = {cfg.left_center[63], cfg.left_center}
			- {cfg.right_center[63], cfg.right_center};
		xs    = xdiff[64] ^ xdiff[63];
		xsat  = xdiff[64] ? Q_MIN : Q_MAX;

		ssum  = {s_q[63], s_q} + {mul_p[63], mul_p};
		ss    = ssum[64] ^ ssum[63];
		ssat  = ssum[64] ? Q_MIN : Q_MAX;

		if (|n_q[63:6])
			scaled = '0;
		else if (n_q[5:0] == 6'd0)
			scaled = acc_q;
		else
			scaled = (acc_q + (64'd1 << (n_q[5:0] - 6'd1))) >> n_q[5:0];
	end

	always_comb begin
		mul_start = (state_q == S_MGO) || (state_q == S_XMGO) || (state_q == S_FGO);
		mul_a = mu_q;
		mul_b = xx_q;
		case (state_q)
			S_XMGO: begin
				mul_a = r_q;
				mul_b = acc_q;
			end
			S_FGO: begin
				case (term_q)
					2'd0: mul_a = d0_q;
					2'd1: mul_a = (lvl_q < i_q) ? xpa_q : xpb_q;
					default: mul_a = {13'd0, cell_q + 4'd1, 47'd0};
				endcase
				if ((term_q == 2'd0 && cell_q == 4'd0) ||
					(term_q == 2'd2 && cell_q == LAST_CELL))
					mul_b = '0;
				else
					mul_b = rd_data_q;
			end
			default: begin
				case (step_q)
					ST_XPA: begin
						mul_a = -bp_q;
						mul_b = x_q;
					end
					ST_XPB: begin
						mul_a = ap_q;
						mul_b = x_q;
					end
					ST_MU: begin
						mul_a = {1'b0, cfg.left_exponent};
						mul_b = bp_q;
					end
					ST_XX: begin
						mul_a = x_q;
						mul_b = x_q;
					end
					default: begin
						mul_a = mu_q;
						mul_b = xx_q;
					end
				endcase
			end
		endcase
	end

	always_comb begin
		div_start = (state_q == S_DGO) || (state_q == S_XDGO);
		div_it    = IT_Q;
		div_den   = p;
		if (state_q == S_XDGO) begin
			div_dvd = {tmp_q[47:0], 63'd0};
			div_den = {59'd0, k_q};
			div_it  = IT_K;
		end else begin
			case (step_q)
				ST_HALF: div_dvd = {HALF_Q, 47'd0};
				ST_BP:   div_dvd = {1'b0, cfg.right_exponent, 47'd0};
				ST_AP:   div_dvd = {1'b0, cfg.left_exponent, 47'd0};
				default: begin
					div_dvd = {arg_q, 47'd0};
					div_den = LN2_Q;
					div_it  = IT_INT;
				end
			endcase
		end
	end

	always_comb begin
		rd_row  = cur_q;
		rd_cell = tdeg_q;
		if (state_q == S_FRD) begin
			case (term_q)
				2'd0: rd_cell = cell_q - 4'd1;
				2'd1: rd_cell = cell_q;
				default: rd_cell = cell_q + 4'd1;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_row][rd_cell];
		if (state_q == S_CLEAR)
			mem[cur_q][cell_q] <= (cell_q == 4'd0) ? e00_q : 64'd0;
		else if (state_q == S_FWR)
			mem[~cur_q][cell_q] <= s_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
			cell_q  <= '0;
			term_q  <= '0;
			lvl_q   <= '0;
			k_q     <= '0;
			cur_q   <= 1'b0;
			ovf_q   <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						ovf_q <= clamp;
						if (in_word.hermite_degree > total)
							state_q <= S_DONE;
						else
							state_q <= S_SETUP;
					end
				end
				S_SETUP: begin
					ovf_q   <= ovf_q | xs;
					step_q  <= ST_HALF;
					state_q <= S_DGO;
				end
				S_DGO: state_q <= S_DWAIT;
				S_DWAIT: begin
					if (div_done) begin
						ovf_q  <= ovf_q | div_sat;
						step_q <= step_q + 4'd1;
						if (step_q == ST_AP) begin
							state_q <= S_MGO;
						end else if (step_q == ST_LN2) begin
							k_q     <= 5'(EXP_TERMS);
							state_q <= S_XMGO;
						end else begin
							state_q <= S_DGO;
						end
					end
				end
				S_MGO: state_q <= S_MWAIT;
				S_MWAIT: begin
					if (mul_done) begin
						ovf_q   <= ovf_q | mul_sat;
						step_q  <= step_q + 4'd1;
						state_q <= (step_q == ST_ARG) ? S_DGO : S_MGO;
					end
				end
				S_XMGO: state_q <= S_XMWAIT;
				S_XMWAIT: begin
					if (mul_done) begin
						ovf_q   <= ovf_q | mul_sat;
						state_q <= S_XDGO;
					end
				end
				S_XDGO: state_q <= S_XDWAIT;
				S_XDWAIT: begin
					if (div_done) begin
						k_q     <= k_q - 5'd1;
						state_q <= (k_q == 5'd1) ? S_SCALE : S_XMGO;
					end
				end
				S_SCALE: begin
					cur_q   <= 1'b0;
					cell_q  <= '0;
					state_q <= S_CLEAR;
				end
				S_CLEAR: begin
					if (cell_q == LAST_CELL) begin
						cell_q  <= '0;
						term_q  <= '0;
						lvl_q   <= '0;
						state_q <= (tot_q == 4'd0) ? S_ORD : S_FRD;
					end else begin
						cell_q <= cell_q + 4'd1;
					end
				end
				S_FRD: state_q <= S_FGO;
				S_FGO: state_q <= S_FWAIT;
				S_FWAIT: begin
					if (mul_done) begin
						ovf_q <= ovf_q | mul_sat | ss;
						if (term_q == 2'd2) begin
							state_q <= S_FWR;
						end else begin
							term_q  <= term_q + 2'd1;
							state_q <= S_FRD;
						end
					end
				end
				S_FWR: begin
					term_q <= '0;
					if (cell_q == LAST_CELL) begin
						cell_q <= '0;
						cur_q  <= ~cur_q;
						lvl_q  <= lvl_q + 3'd1;
						if ({1'b0, lvl_q} + 4'd1 == tot_q)
							state_q <= S_ORD;
						else
							state_q <= S_FRD;
					end else begin
						cell_q  <= cell_q + 4'd1;
						state_q <= S_FRD;
					end
				end
				S_ORD: state_q <= S_OLAT;
				S_OLAT: state_q <= S_DONE;
				S_DONE: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				i_q    <= ic;
				j_q    <= jc;
				tot_q  <= total;
				tdeg_q <= in_word.hermite_degree;
				coef_q <= '0;
			end
			S_SETUP: x_q <= xs ? xsat : xdiff[63:0];
			S_DWAIT: begin
				case (step_q)
					ST_HALF: d0_q <= div_quo;
					ST_BP:   bp_q <= div_quo;
					ST_AP:   ap_q <= div_quo;
					default: begin
						n_q   <= div_quo;
						r_q   <= div_rem;
						acc_q <= ONE_Q;
					end
				endcase
			end
			S_MWAIT: begin
				case (step_q)
					ST_XPA:  xpa_q <= mul_p;
					ST_XPB:  xpb_q <= mul_p;
					ST_MU:   mu_q  <= mul_p;
					ST_XX:   xx_q  <= mul_p;
					default: arg_q <= mul_p;
				endcase
			end
			S_XMWAIT: tmp_q <= mul_p;
			S_XDWAIT: acc_q <= ONE_Q - div_quo;
			S_SCALE: begin
				e00_q <= scaled;
				s_q   <= '0;
			end
			S_FWAIT: begin
				if (mul_done)
					s_q <= ss ? ssat : ssum[63:0];
			end
			S_FWR: s_q <= '0;
			S_OLAT: coef_q <= rd_data_q;
			default: ;
		endcase
	end

	hec_qmul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (mul_p),
		.sat    (mul_sat)
	);

	hec_qdiv u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.dvd    (div_dvd),
		.den    (div_den),
		.iters  (div_it),
		.done   (div_done),
		.quo    (div_quo),
		.rem    (div_rem),
		.sat    (div_sat)
	);

	assign busy               = (state_q != S_IDLE);
	assign done               = (state_q == S_DONE) && out_free;
	assign result.coefficient = coef_q;
	assign result.overflow    = ovf_q;

endmodule

[hdl/hermite_expansion_coefficient.sv]
// Flow: when the degree exceeds i+j the sequencer skips set-up and returns a
//   zero coefficient; otherwise it runs set-up, the exponential seed, one fill
//   pass for each of the i+j levels, and read-out.
// Input: one word at a time; the next word is taken in the cycle after the
//   result leaves the sequencer. The shared restoring divider (one bit a
//   cycle) and the multiplier set how long each word takes.
// Reset: arst_n clears control and loads the register reset values.
// ----------------------------------------------------------------------------
// Hermite expansion coefficient - top level
// Configuration registers, input handshake and output register.
// ----------------------------------------------------------------------------
module hermite_expansion_coefficient (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  hec_pkg::hec_in_t  in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output hec_pkg::hec_out_t out_data,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [4:0]        paddr,
	input  logic [63:0]       pwdata,
	output logic [63:0]       prdata,
	output logic              pready
);
	import hec_pkg::*;

	hec_cfg_t cfg_q;
	hec_out_t out_q, res;
	logic     out_valid_q, busy, done, out_free, start;
	logic [1:0] idx;

	assign idx      = paddr[4:3];
	assign pready   = 1'b1;
	assign start    = in_valid & ~busy;
	assign out_free = ~out_valid_q | ~out_stall;

	always_comb begin
		case (idx)
			REG_LEFT_CENTER:    prdata = cfg_q.left_center;
			REG_LEFT_EXPONENT:  prdata = {1'b0, cfg_q.left_exponent};
			REG_RIGHT_CENTER:   prdata = cfg_q.right_center;
			REG_RIGHT_EXPONENT: prdata = {1'b0, cfg_q.right_exponent};
			default:            prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.left_center    <= '0;
			cfg_q.left_exponent  <= ONE_Q[62:0];
			cfg_q.right_center   <= '0;
			cfg_q.right_exponent <= ONE_Q[62:0];
		end else if (psel && penable && pwrite) begin
			case (idx)
				REG_LEFT_CENTER:    cfg_q.left_center    <= pwdata;
				REG_LEFT_EXPONENT:  cfg_q.left_exponent  <= pwdata[62:0];
				REG_RIGHT_CENTER:   cfg_q.right_center   <= pwdata;
				REG_RIGHT_EXPONENT: cfg_q.right_exponent <= pwdata[62:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done)
			out_q <= res;
	end

	hec_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.in_word  (in_data),
		.cfg      (cfg_q),
		.out_free (out_free),
		.busy     (busy),
		.done     (done),
		.result   (res)
	);

	assign in_stall  = busy;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
